/* design/mmes_pkg.sv */
package mmes_pkg;

  // Normalised values are Q1.16 with 1.0 as 65536, so they need 17 bits.
  localparam int unsigned NORM_BITS = 17;
  localparam logic [NORM_BITS-1:0] NORM_ONE = 17'h10000;
  localparam int unsigned ALPHA_BITS = 16;
  localparam logic [ALPHA_BITS-1:0] ALPHA_RESET = 16'h8000;
  // Smoothing accumulator: alpha * n + (1 - alpha) * s + half fits in 34 bits.
  localparam int unsigned ACC_W = 34;
  localparam logic [ACC_W-1:0] ACC_HALF = 34'h0_0000_8000;
  localparam int unsigned DIV_CW = $clog2(NORM_BITS + 1);

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_EQUAL    = 2'd1,
    STAT_OVERFLOW = 2'd2
  } stat_e;

  typedef logic [3:0] step_t;

  localparam step_t STEP_LOAD    = 4'd0;
  localparam step_t STEP_CHECK   = 4'd1;
  localparam step_t STEP_EMIT_EQ = 4'd2;
  localparam step_t STEP_READ    = 4'd3;
  localparam step_t STEP_DIV_GO  = 4'd4;
  localparam step_t STEP_DIV_WT  = 4'd5;
  localparam step_t STEP_MUL1    = 4'd6;
  localparam step_t STEP_MUL2    = 4'd7;
  localparam step_t STEP_EMIT    = 4'd8;
  localparam step_t STEP_CLEAR   = 4'd9;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_CHECK,
    ACT_EMIT_EQ,
    ACT_READ,
    ACT_DIV_GO,
    ACT_MUL1,
    ACT_MUL2,
    ACT_EMIT,
    ACT_CLEAR
  } act_e;

  typedef enum logic [1:0] {
    HOLD_NONE,
    HOLD_WAIT_LAST,
    HOLD_DIV,
    HOLD_OUT
  } hold_e;

  typedef enum logic [1:0] {
    BR_NONE,
    BR_ALWAYS,
    BR_NOT_EQ,
    BR_MORE
  } br_e;

  typedef struct packed {
    logic  in_ready;
    act_e  act;
    hold_e hold;
    br_e   br;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic last_acc;
    logic equal;
    logic div_busy;
    logic out_busy;
    logic more;
  } seq_stat_t;

  // Microprogram. A step stays while its hold condition is true, otherwise
  // it goes to its target when the branch condition holds, else to the next.
  function automatic ctrl_t urom(input step_t s);
    ctrl_t w;
    w = '{in_ready: 1'b0, act: ACT_NONE, hold: HOLD_NONE, br: BR_ALWAYS,
          target: STEP_LOAD};
    unique case (s)
      STEP_LOAD: begin
        w = '{1'b1, ACT_LOAD, HOLD_WAIT_LAST, BR_NONE, STEP_LOAD};
      end
      STEP_CHECK: begin
        w = '{1'b0, ACT_CHECK, HOLD_NONE, BR_NOT_EQ, STEP_READ};
      end
      STEP_EMIT_EQ: begin
        w = '{1'b0, ACT_EMIT_EQ, HOLD_OUT, BR_ALWAYS, STEP_CLEAR};
      end
      STEP_READ: begin
        w = '{1'b0, ACT_READ, HOLD_NONE, BR_NONE, STEP_LOAD};
      end
      STEP_DIV_GO: begin
        w = '{1'b0, ACT_DIV_GO, HOLD_NONE, BR_NONE, STEP_LOAD};
      end
      STEP_DIV_WT: begin
        w = '{1'b0, ACT_NONE, HOLD_DIV, BR_NONE, STEP_LOAD};
      end
      STEP_MUL1: begin
        w = '{1'b0, ACT_MUL1, HOLD_NONE, BR_NONE, STEP_LOAD};
      end
      STEP_MUL2: begin
        w = '{1'b0, ACT_MUL2, HOLD_NONE, BR_NONE, STEP_LOAD};
      end
      STEP_EMIT: begin
        w = '{1'b0, ACT_EMIT, HOLD_OUT, BR_MORE, STEP_READ};
      end
      STEP_CLEAR: begin
        w = '{1'b0, ACT_CLEAR, HOLD_NONE, BR_ALWAYS, STEP_LOAD};
      end
      default: begin
        w = '{1'b0, ACT_NONE, HOLD_NONE, BR_ALWAYS, STEP_LOAD};
      end
    endcase
    return w;
  endfunction

endpackage

/* design/mmes_if.sv */
interface mmes_in_if #(
  parameter int unsigned SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          end_of_series;

  modport source (output valid, output sample, output end_of_series, input ready);
  modport sink   (input valid, input sample, input end_of_series, output ready);
endinterface

interface mmes_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] smoothed_value;
  logic [1:0]  status;
  logic        last_result;

  modport source (output valid, output smoothed_value, output status,
                  output last_result, input ready);
  modport sink   (input valid, input smoothed_value, input status,
                  input last_result, output ready);
endinterface

/* design/mmes_seq.sv */
module mmes_seq
  import mmes_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  seq_stat_t stat_i,
  output ctrl_t     ctrl_o
);

  step_t step_q, step_d;
  ctrl_t word;
  logic  hold_c;
  logic  br_c;

  assign word = urom(step_q);

  always_comb begin
    case (word.hold)
      HOLD_WAIT_LAST: hold_c = !stat_i.last_acc;
      HOLD_DIV:       hold_c = stat_i.div_busy;
      HOLD_OUT:       hold_c = stat_i.out_busy;
      default:        hold_c = 1'b0;
    endcase
    case (word.br)
      BR_ALWAYS: br_c = 1'b1;
      BR_NOT_EQ: br_c = !stat_i.equal;
      BR_MORE:   br_c = stat_i.more;
      default:   br_c = 1'b0;
    endcase
    if (hold_c) begin
      step_d = step_q;
    end else if (br_c) begin
      step_d = word.target;
    end else begin
      step_d = step_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_LOAD;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o = word;

endmodule

/* design/mmes_div.sv */
module mmes_div
  import mmes_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [SAMPLE_BITS+NORM_BITS-1:0]     dividend_i,
  input  logic [SAMPLE_BITS-1:0]               divisor_i,
  output logic                                 busy_o,
  output logic [NORM_BITS-1:0]                 quot_o
);

  // Restoring division, one quotient bit per cycle. The quotient is known to
  // fit in NORM_BITS, so the upper dividend bits start below the divisor.
  logic [SAMPLE_BITS-1:0] rem_q, rem_d;
  logic [NORM_BITS-1:0]   low_q, low_d;
  logic [SAMPLE_BITS-1:0] dvs_q;
  logic [DIV_CW-1:0]      cnt_q;
  logic [SAMPLE_BITS:0]   trial;
  logic [SAMPLE_BITS:0]   diff;
  logic                   ge;

  assign trial = {rem_q, low_q[NORM_BITS-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    rem_d = ge ? diff[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
    low_d = {low_q[NORM_BITS-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= DIV_CW'(NORM_BITS);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[SAMPLE_BITS+NORM_BITS-1:NORM_BITS];
      low_q <= dividend_i[NORM_BITS-1:0];
      dvs_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      low_q <= low_d;
    end
  end

  assign busy_o = cnt_q != '0;
  assign quot_o = low_q;

endmodule

/* design/minmax_normalize_ema_smoother_core.sv */
// Min-max normaliser with exponential smoothing.
// Samples arrive as requests on in_i (valid/ready), one per cycle while the
// block is loading; each is stored and folds into the running minimum and
// maximum. Samples beyond DEPTH are dropped and mark the run as overflowed.
// The request with end_of_series set is stored like the others and starts
// the output run: one result per stored sample on out_o, the final one
// flagged by last_result. A series whose samples are all equal gives a
// single result with status 1 instead.
// During the run the block takes no input. Each result passes through the read,
// divider start, divider wait, first and second multiply and emit steps, the
// wait lasting while the bit-serial divider is busy; after the last result a
// clear step empties the series and the block loads again.
// A registered output stage holds a result while the receiver stalls; the
// microprogram simply waits on its emit step until the stage frees.
// The user must write the smoothing factor through cfg_we_i/cfg_wdata_i only
// while idle; the block does not enforce this. Reset empties the series, sets
// the factor to one half and returns the microprogram to its loading step.
module minmax_normalize_ema_smoother_core
  import mmes_pkg::*;
#(
  parameter int unsigned DEPTH       = 64,
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  mmes_in_if.sink               in_i,
  mmes_out_if.source            out_o,
  input  logic                  cfg_we_i,
  input  logic [ALPHA_BITS-1:0] cfg_wdata_i
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned DW = SAMPLE_BITS + NORM_BITS;
  localparam logic signed [SAMPLE_BITS-1:0] MAX_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] MAX_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  ctrl_t     ctrl;
  seq_stat_t stat;

  // Series state.
  logic signed [SAMPLE_BITS-1:0] mem [DEPTH];
  logic signed [SAMPLE_BITS-1:0] rd_q;
  logic signed [SAMPLE_BITS-1:0] min_q;
  logic signed [SAMPLE_BITS-1:0] max_q;
  logic [CW-1:0]                 cnt_q;
  logic                          ovf_q;
  logic [ALPHA_BITS-1:0]         alpha_q;

  // Run state.
  logic [SAMPLE_BITS-1:0] range_q;
  logic [CW-1:0]          idx_q;
  stat_e                  stat_q;
  logic [NORM_BITS-1:0]   prev_q;
  logic [ACC_W-1:0]       acc1_q;
  logic [ACC_W-1:0]       acc2_q;

  // Output stage.
  logic                 out_valid_q;
  logic [NORM_BITS-1:0] out_val_q;
  stat_e                out_stat_q;
  logic                 out_last_q;

  logic                   accept;
  logic                   has_room;
  logic                   out_free;
  logic                   out_load;
  logic                   div_start;
  logic                   div_busy;
  logic [NORM_BITS-1:0]   div_quot;
  logic [NORM_BITS-1:0]   norm;
  logic [SAMPLE_BITS:0]   offset_w;
  logic [DW-1:0]          dividend;
  logic [NORM_BITS-1:0]   one_minus;
  logic [ACC_W-16-1:0]    acc_hi;
  logic [NORM_BITS-1:0]   smooth;
  logic                   is_last;

  mmes_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  mmes_div #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (range_q),
    .busy_o     (div_busy),
    .quot_o     (div_quot)
  );

  assign in_i.ready = ctrl.in_ready;
  assign accept     = in_i.valid && ctrl.in_ready;
  assign has_room   = cnt_q < CW'(DEPTH);
  assign out_free   = !out_valid_q || out_o.ready;
  assign is_last    = (idx_q + 1'b1) == cnt_q;
  assign div_start  = ctrl.act == ACT_DIV_GO;
  assign out_load   = out_free && (ctrl.act == ACT_EMIT || ctrl.act == ACT_EMIT_EQ);

  assign stat.last_acc = accept && in_i.end_of_series;
  assign stat.equal    = min_q >= max_q;
  assign stat.div_busy = div_busy;
  assign stat.out_busy = !out_free;
  assign stat.more     = !is_last;

  // Offset from the minimum is non-negative and below 2^SAMPLE_BITS.
  assign offset_w = {rd_q[SAMPLE_BITS-1], rd_q} - {min_q[SAMPLE_BITS-1], min_q};
  assign dividend = {1'b0, offset_w[SAMPLE_BITS-1:0], 16'h0000}
                  + DW'(range_q >> 1);

  assign norm      = (div_quot > NORM_ONE) ? NORM_ONE : div_quot;
  assign one_minus = NORM_ONE - {1'b0, alpha_q};
  assign acc_hi    = acc2_q[ACC_W-1:16];
  always_comb begin
    if (idx_q == '0) begin
      smooth = norm;
    end else if (acc_hi > {{(ACC_W-16-NORM_BITS){1'b0}}, NORM_ONE}) begin
      smooth = NORM_ONE;
    end else begin
      smooth = acc_hi[NORM_BITS-1:0];
    end
  end

  // Sample store: one write port while loading, one registered read port.
  always_ff @(posedge clk_i) begin
    if (ctrl.act == ACT_LOAD && accept && has_room) begin
      mem[cnt_q[AW-1:0]] <= in_i.sample;
    end
    rd_q <= mem[idx_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= ALPHA_RESET;
    end else if (cfg_we_i) begin
      alpha_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q  <= MAX_POS;
      max_q  <= MAX_NEG;
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
      prev_q <= '0;
    end else begin
      unique case (ctrl.act)
        ACT_LOAD: begin
          if (accept) begin
            if (has_room) begin
              cnt_q <= cnt_q + 1'b1;
              if (in_i.sample < min_q) begin
                min_q <= in_i.sample;
              end
              if (in_i.sample > max_q) begin
                max_q <= in_i.sample;
              end
            end else begin
              ovf_q <= 1'b1;
            end
          end
        end
        ACT_EMIT: begin
          if (out_free) begin
            prev_q <= smooth;
          end
        end
        ACT_CLEAR: begin
          min_q  <= MAX_POS;
          max_q  <= MAX_NEG;
          cnt_q  <= '0;
          ovf_q  <= 1'b0;
          prev_q <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Run datapath registers carry no reset: every run sets them before use.
  always_ff @(posedge clk_i) begin
    unique case (ctrl.act)
      ACT_CHECK: begin
        range_q <= max_q - min_q;
        idx_q   <= '0;
        stat_q  <= ovf_q ? STAT_OVERFLOW : STAT_OK;
      end
      ACT_MUL1: begin
        acc1_q <= ACC_W'(alpha_q) * ACC_W'(norm) + ACC_HALF;
      end
      ACT_MUL2: begin
        acc2_q <= acc1_q + ACC_W'(one_minus) * ACC_W'(prev_q);
      end
      ACT_EMIT: begin
        if (out_free) begin
          idx_q <= idx_q + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (ctrl.act == ACT_EMIT_EQ) begin
        out_val_q  <= '0;
        out_stat_q <= STAT_EQUAL;
        out_last_q <= 1'b1;
      end else begin
        out_val_q  <= smooth;
        out_stat_q <= stat_q;
        out_last_q <= is_last;
      end
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.smoothed_value = out_val_q;
  assign out_o.status         = out_stat_q;
  assign out_o.last_result    = out_last_q;

`ifndef SYNTH
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("sample count beyond the store depth");

  a_ovf_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> cnt_q == CW'(DEPTH))
    else $error("overflow flagged while the store still has room");

  a_div_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_no_load_in_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !ctrl.in_ready)
    else $error("input taken while a result is being produced");
`endif

endmodule
